// ----- hdl/dvrt_pkg.sv -----
// ----------------------------------------------------------------------------
// Route table package
// Types and constants shared by the route table controller, datapath and top.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int ENTRIES   = 32;
  localparam int IDX_BITS  = $clog2(ENTRIES);
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int ADDR_BITS = 16;
  localparam int HOP_BITS  = 8;
  localparam int REQ_BITS  = 3;

  localparam logic [HOP_BITS-1:0]  HOP_MAX    = {HOP_BITS{1'b1}};
  localparam logic [HOP_BITS-1:0]  HOP_ONE    = HOP_BITS'(1);
  localparam logic [ADDR_BITS-1:0] ADDR_BCAST = {ADDR_BITS{1'b1}};

  localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_ADVERT = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_ADD    = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 3'd4;

  typedef struct packed {
    logic [REQ_BITS-1:0]  req_type;
    logic [ADDR_BITS-1:0] dest_node;
    logic [ADDR_BITS-1:0] neighbor_node;
    logic [HOP_BITS-1:0]  hop_value;
    logic                 first_of_advert;
  } req_t;

  typedef struct packed {
    logic                 found;
    logic [ADDR_BITS-1:0] next_hop;
    logic [HOP_BITS-1:0]  hop_count;
    logic                 changed;
    logic                 table_full;
    logic [CNT_BITS-1:0]  entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_NBR_INS = 3'd1,
    OP_ADVERT  = 3'd2,
    OP_ADD     = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef struct packed {
    logic load;
    logic match_en;
    logic match_nbr;
    op_t  op;
    logic emit;
  } dp_cmd_t;

endpackage

// ----- hdl/dvrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Route table controller
// Sequences the match, update and result steps of each request.
// ----------------------------------------------------------------------------
module dvrt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  dvrt_pkg::req_t request,
  output logic           busy,
  output dvrt_pkg::dp_cmd_t cmd
);
  import dvrt_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_NBR_MATCH = 7'b0000010,
    S_NBR_ACT   = 7'b0000100,
    S_DST_MATCH = 7'b0001000,
    S_DST_ACT   = 7'b0010000,
    S_RES_MATCH = 7'b0100000,
    S_RES_OUT   = 7'b1000000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [REQ_BITS-1:0] req_type;
  logic                lookup_only;
  op_t                 dst_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      req_type <= REQ_LOOKUP;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) begin
        req_type <= request.req_type;
      end
    end
  end

  always_comb begin
    lookup_only = !(req_type inside {REQ_ADVERT, REQ_ADD, REQ_REMOVE, REQ_CLEAR});
    case (req_type)
      REQ_ADVERT: dst_op = OP_ADVERT;
      REQ_ADD:    dst_op = OP_ADD;
      REQ_REMOVE: dst_op = OP_REMOVE;
      REQ_CLEAR:  dst_op = OP_CLEAR;
      default:    dst_op = OP_NONE;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (request.req_type == REQ_ADVERT && request.first_of_advert) begin
            state_next = S_NBR_MATCH;
          end else begin
            state_next = S_DST_MATCH;
          end
        end
      end
      S_NBR_MATCH: state_next = S_NBR_ACT;
      S_NBR_ACT:   state_next = S_DST_MATCH;
      S_DST_MATCH: state_next = lookup_only ? S_RES_OUT : S_DST_ACT;
      S_DST_ACT:   state_next = S_RES_MATCH;
      S_RES_MATCH: state_next = S_RES_OUT;
      S_RES_OUT:   state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state != S_IDLE);
    cmd.load      = (state == S_IDLE) && start;
    cmd.match_en  = (state == S_NBR_MATCH) || (state == S_DST_MATCH) ||
                    (state == S_RES_MATCH);
    cmd.match_nbr = (state == S_NBR_MATCH);
    cmd.emit      = (state == S_RES_OUT);
    case (state)
      S_NBR_ACT: cmd.op = OP_NBR_INS;
      S_DST_ACT: cmd.op = dst_op;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- hdl/dvrt_dpath.sv -----
// ----------------------------------------------------------------------------
// Route table datapath
// Holds the routes, matches a key against all entries and applies updates.
// ----------------------------------------------------------------------------
module dvrt_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  dvrt_pkg::dp_cmd_t              cmd,
  input  dvrt_pkg::req_t                 request,
  input  logic [dvrt_pkg::ADDR_BITS-1:0] own_address,
  output dvrt_pkg::rsp_t                 result,
  output logic                           result_valid
);
  import dvrt_pkg::*;

  logic [ENTRIES-1:0]   valid;
  logic [ADDR_BITS-1:0] dest_arr [ENTRIES];
  logic [ADDR_BITS-1:0] next_arr [ENTRIES];
  logic [HOP_BITS-1:0]  hops_arr [ENTRIES];
  logic [CNT_BITS-1:0]  count;
  logic                 changed;
  logic                 dropped;

  logic [ADDR_BITS-1:0] dest_r;
  logic [ADDR_BITS-1:0] nbr_r;
  logic [HOP_BITS-1:0]  hv_r;
  logic [HOP_BITS-1:0]  nh_r;

  logic [ENTRIES-1:0]   hit_vec;
  logic [ENTRIES-1:0]   free_vec;
  logic [IDX_BITS-1:0]  hit_idx;
  logic [IDX_BITS-1:0]  free_idx;
  logic                 hit_any;
  logic                 free_any;
  logic [ADDR_BITS-1:0] key;
  logic [ADDR_BITS-1:0] next_rd;
  logic [HOP_BITS-1:0]  hops_rd;

  logic                 ins;
  logic                 upd;
  logic                 rem;
  logic                 clr;
  logic                 chg_set;
  logic                 chg_clr;
  logic                 drop;
  logic [ADDR_BITS-1:0] dest_w;
  logic [ADDR_BITS-1:0] next_w;
  logic [HOP_BITS-1:0]  hops_w;
  logic [IDX_BITS-1:0]  wr_idx;

  assign key = cmd.match_nbr ? nbr_r : dest_r;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_BITS'(i);
      end
      if (free_vec[i]) begin
        free_idx = IDX_BITS'(i);
      end
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = |free_vec;
  assign next_rd  = next_arr[hit_idx];
  assign hops_rd  = hops_arr[hit_idx];
  assign wr_idx   = ins ? free_idx : hit_idx;

  always_comb begin
    ins     = 1'b0;
    upd     = 1'b0;
    rem     = 1'b0;
    clr     = 1'b0;
    chg_set = 1'b0;
    chg_clr = 1'b0;
    drop    = 1'b0;
    dest_w  = dest_r;
    next_w  = nbr_r;
    hops_w  = nh_r;
    case (cmd.op)
      OP_NBR_INS: begin
        chg_clr = 1'b1;
        dest_w  = nbr_r;
        hops_w  = HOP_ONE;
        if (!hit_any) begin
          ins     = free_any;
          chg_set = free_any;
          drop    = !free_any;
        end
      end
      OP_ADVERT: begin
        if (dest_r != own_address) begin
          if (hit_any) begin
            upd     = (hops_rd > nh_r);
            chg_set = (hops_rd > nh_r);
          end else begin
            ins     = free_any;
            chg_set = free_any;
            drop    = !free_any;
          end
        end
      end
      OP_ADD: begin
        hops_w = hv_r;
        if (hit_any) begin
          upd = 1'b1;
        end else begin
          ins  = free_any;
          drop = !free_any;
        end
      end
      OP_REMOVE: rem = hit_any;
      OP_CLEAR:  clr = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dest_r <= request.dest_node;
      nbr_r  <= request.neighbor_node;
      hv_r   <= request.hop_value;
      nh_r   <= (request.hop_value == HOP_MAX) ? HOP_MAX : request.hop_value + HOP_ONE;
    end
    if (cmd.match_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        hit_vec[i] <= valid[i] && (dest_arr[i] == key);
      end
      free_vec <= ~valid;
    end
    if (ins || upd) begin
      next_arr[wr_idx] <= next_w;
      hops_arr[wr_idx] <= hops_w;
    end
    if (ins) begin
      dest_arr[wr_idx] <= dest_w;
    end
    if (cmd.emit) begin
      result.found       <= hit_any;
      result.next_hop    <= hit_any ? next_rd : ADDR_BCAST;
      result.hop_count   <= hit_any ? hops_rd : '0;
      result.changed     <= changed;
      result.table_full  <= dropped;
      result.entry_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      count        <= '0;
      changed      <= 1'b0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.load) begin
        dropped <= 1'b0;
      end else if (drop) begin
        dropped <= 1'b1;
      end
      if (chg_set) begin
        changed <= 1'b1;
      end else if (chg_clr) begin
        changed <= 1'b0;
      end
      if (clr) begin
        valid <= '0;
        count <= '0;
      end else if (ins) begin
        valid[free_idx] <= 1'b1;
        count           <= count + CNT_BITS'(1);
      end else if (rem) begin
        valid[hit_idx] <= 1'b0;
        count          <= count - CNT_BITS'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(ENTRIES))
    else $error("Route count exceeds the table size.");

  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("Route count disagrees with the valid bits.");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $onehot0(hit_vec))
    else $error("A destination matched more than one entry.");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.table_full |-> result.entry_count == CNT_BITS'(ENTRIES))
    else $error("An insert was dropped while the table had room.");

endmodule

// ----- hdl/distance_vector_route_table_top.sv -----
// ----------------------------------------------------------------------------
// Distance-vector route table
// Route table with lookup, add, remove, clear and neighbor advertisements.
// ----------------------------------------------------------------------------
//  Channel   Handshake                      Payload
//  request   start high, busy low           request (req_t)
//  result    result_valid, one-cycle strobe result (rsp_t)
//  config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
//  A lookup or an unused request code runs a destination match, then output;
//  add, remove, clear and plain advertised entries update and rematch before
//  output, and the first advertised entry begins with a neighbor match and insert.
//  A new request is accepted on the cycle its predecessor's result is shown.
//  Reset clears all routes at once; no clearing pass is needed.
//  The result receiver cannot stall the block.
// ----------------------------------------------------------------------------
module distance_vector_route_table_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dvrt_pkg::req_t request,
  output logic           result_valid,
  output dvrt_pkg::rsp_t result,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import dvrt_pkg::*;

  localparam logic [1:0] REG_OWN_ADDR = 2'd0;

  logic [ADDR_BITS-1:0] own_address;
  dp_cmd_t              cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_OWN_ADDR) ? 32'(own_address) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (psel && penable && pwrite && pready && paddr == REG_OWN_ADDR) begin
      own_address <= pwdata[ADDR_BITS-1:0];
    end
  end

  dvrt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .cmd     (cmd)
  );

  dvrt_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .request      (request),
    .own_address  (own_address),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ----- bench/distance_vector_route_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table testbench
// Drives lookups, direct adds, removes, clears and neighbor advertisements
// into the route table, with random gaps between requests, and checks every
// result against a local model of the table. The node address is changed
// between phases through the register port and read back.
// ----------------------------------------------------------------------------
module distance_vector_route_table_top_tb;
  import dvrt_pkg::*;

  localparam logic [1:0]          OWN_ADDR_REG   = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [REQ_BITS-1:0] REQ_RSVD_LAST  = 3'd7;
  localparam logic [ADDR_BITS-1:0] OWN_ADDR_MAX  = 16'hFFFE;
  localparam int POOL_SIZE      = 40;
  localparam int PHASE_REQUESTS = 450;
  localparam int SETTLE_CYCLES  = 12;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int PRINT_LIMIT    = 40;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        result_valid;
  rsp_t        result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic                 route_valid [ENTRIES];
  logic [ADDR_BITS-1:0] route_dest  [ENTRIES];
  logic [ADDR_BITS-1:0] route_next  [ENTRIES];
  logic [HOP_BITS-1:0]  route_hops  [ENTRIES];
  logic                 route_changed;
  int                   route_count;
  logic [ADDR_BITS-1:0] own_addr;

  rsp_t                 expected_replies [$];
  rsp_t                 reply_want;
  logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];
  int                   mismatches;
  int                   requests_sent;
  int                   gap_pct;
  int                   cycle_count;

  distance_vector_route_table_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("distance_vector_route_table_top_tb: done, errors");
      $finish;
    end
  end

  function automatic int find_route(input logic [ADDR_BITS-1:0] dest);
    for (int i = 0; i < ENTRIES; i++)
      if (route_valid[i] && route_dest[i] == dest) return i;
    return -1;
  endfunction

  // Overwrites a known route or takes the lowest free entry; 0 when full.
  function automatic bit store_route(input logic [ADDR_BITS-1:0] dest,
                                     input logic [ADDR_BITS-1:0] nxt,
                                     input logic [HOP_BITS-1:0] hops);
    int slot;
    slot = find_route(dest);
    if (slot < 0) begin
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (!route_valid[i]) slot = i;
      if (slot < 0) return 1'b0;
      route_valid[slot] = 1'b1;
      route_dest[slot]  = dest;
      route_count++;
    end
    route_next[slot] = nxt;
    route_hops[slot] = hops;
    return 1'b1;
  endfunction

  function automatic rsp_t route_table_apply(input req_t req);
    rsp_t                reply;
    logic                dropped;
    logic [HOP_BITS:0]   bumped;
    logic [HOP_BITS-1:0] adv_hops;
    int                  slot;
    dropped = 1'b0;
    case (req.req_type)
      REQ_ADVERT: begin
        if (req.first_of_advert) begin
          route_changed = 1'b0;
          if (find_route(req.neighbor_node) < 0) begin
            if (store_route(req.neighbor_node, req.neighbor_node, HOP_ONE))
              route_changed = 1'b1;
            else
              dropped = 1'b1;
          end
        end
        if (req.dest_node != own_addr) begin
          bumped   = {1'b0, req.hop_value} + 1'b1;
          adv_hops = bumped[HOP_BITS] ? HOP_MAX : bumped[HOP_BITS-1:0];
          slot     = find_route(req.dest_node);
          if (slot >= 0) begin
            if (route_hops[slot] > adv_hops) begin
              route_next[slot] = req.neighbor_node;
              route_hops[slot] = adv_hops;
              route_changed    = 1'b1;
            end
          end else if (store_route(req.dest_node, req.neighbor_node, adv_hops)) begin
            route_changed = 1'b1;
          end else begin
            dropped = 1'b1;
          end
        end
      end
      REQ_ADD: begin
        if (!store_route(req.dest_node, req.neighbor_node, req.hop_value)) dropped = 1'b1;
      end
      REQ_REMOVE: begin
        slot = find_route(req.dest_node);
        if (slot >= 0) begin
          route_valid[slot] = 1'b0;
          route_count--;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) route_valid[i] = 1'b0;
        route_count = 0;
      end
      default: ;
    endcase
    slot = find_route(req.dest_node);
    if (slot >= 0) begin
      reply.found     = 1'b1;
      reply.next_hop  = route_next[slot];
      reply.hop_count = route_hops[slot];
    end else begin
      reply.found     = 1'b0;
      reply.next_hop  = ADDR_BCAST;
      reply.hop_count = '0;
    end
    reply.changed     = route_changed;
    reply.table_full  = dropped;
    reply.entry_count = CNT_BITS'(route_count);
    return reply;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
          $display("%0t: result mismatch, expected none, got %0h", $time, result);
      end else begin
        reply_want = expected_replies.pop_front();
        compare_field("found", 32'(reply_want.found), 32'(result.found));
        compare_field("next_hop", 32'(reply_want.next_hop), 32'(result.next_hop));
        compare_field("hop_count", 32'(reply_want.hop_count), 32'(result.hop_count));
        compare_field("changed", 32'(reply_want.changed), 32'(result.changed));
        compare_field("table_full", 32'(reply_want.table_full), 32'(result.table_full));
        compare_field("entry_count", 32'(reply_want.entry_count),
                      32'(result.entry_count));
      end
    end
  end

  // Leaves start high on return so that a following request goes out back to back.
  task automatic send_request(input logic [REQ_BITS-1:0] kind,
                              input logic [ADDR_BITS-1:0] dest,
                              input logic [ADDR_BITS-1:0] nbr,
                              input logic [HOP_BITS-1:0] hops,
                              input logic first);
    req_t req;
    req.req_type        = kind;
    req.dest_node       = dest;
    req.neighbor_node   = nbr;
    req.hop_value       = hops;
    req.first_of_advert = first;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    expected_replies.push_back(route_table_apply(req));
    requests_sent++;
  endtask

  task automatic drain_requests;
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_own_address(input logic [ADDR_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OWN_ADDR_REG;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    own_addr = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field("own_address readback", 32'(value), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [ADDR_BITS-1:0] pick_address();
    if ($urandom_range(9) < 8) return addr_pool[$urandom_range(POOL_SIZE - 1)];
    return ADDR_BITS'($urandom);
  endfunction

  function automatic logic [HOP_BITS-1:0] pick_hops();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return HOP_BITS'($urandom_range(15));
    if (sel < 8) return HOP_BITS'($urandom);
    return HOP_BITS'($urandom_range(HOP_MAX, HOP_MAX - 5));
  endfunction

  task automatic test_own_address_register;
    set_own_address(OWN_ADDR_MAX);
    set_own_address(16'h0100);
  endtask

  task automatic test_lookups_on_empty_table;
    send_request(REQ_LOOKUP, '0, '0, '0, 1'b0);
    for (int code = REQ_RSVD_FIRST; code <= REQ_RSVD_LAST; code++)
      send_request(REQ_BITS'(code), ADDR_BCAST, ADDR_BCAST, HOP_MAX, 1'b1);
    drain_requests();
  endtask

  task automatic test_direct_add;
    send_request(REQ_ADD, '0, ADDR_BCAST, HOP_MAX, 1'b1);
    send_request(REQ_ADD, ADDR_BCAST, '0, '0, 1'b0);
    send_request(REQ_ADD, '0, 16'h00AA, 8'd7, 1'b0);
    send_request(REQ_LOOKUP, '0, '0, '0, 1'b0);
    drain_requests();
  endtask

  task automatic test_advertisement;
    send_request(REQ_ADVERT, 16'h0020, 16'h0010, 8'd3, 1'b1);
    send_request(REQ_ADVERT, 16'h0020, 16'h0011, 8'd3, 1'b0);
    send_request(REQ_ADVERT, 16'h0020, 16'h0011, 8'd9, 1'b0);
    send_request(REQ_ADVERT, 16'h0020, 16'h0011, 8'd1, 1'b0);
    send_request(REQ_ADVERT, own_addr, 16'h0011, 8'd0, 1'b0);
    send_request(REQ_ADVERT, 16'h0030, 16'h0011, HOP_MAX, 1'b0);
    send_request(REQ_ADVERT, 16'h0030, 16'h0010, HOP_MAX - 1'b1, 1'b1);
    send_request(REQ_ADVERT, 16'h0040, 16'h0040, 8'd0, 1'b1);
    send_request(REQ_ADVERT, own_addr, ADDR_BCAST, 8'd0, 1'b1);
    drain_requests();
  endtask

  task automatic test_remove_and_clear;
    send_request(REQ_REMOVE, 16'h7777, '0, '0, 1'b0);
    send_request(REQ_REMOVE, 16'h0020, '0, '0, 1'b0);
    send_request(REQ_CLEAR, 16'h0010, '0, '0, 1'b1);
    send_request(REQ_LOOKUP, 16'h0010, '0, '0, 1'b0);
    drain_requests();
  endtask

  task automatic test_table_full;
    send_request(REQ_CLEAR, '0, '0, '0, 1'b0);
    for (int i = 0; i < ENTRIES; i++)
      send_request(REQ_ADD, ADDR_BITS'(16'h4000 + i), ADDR_BITS'(16'h0200 + i),
                   HOP_BITS'(i), 1'b0);
    send_request(REQ_ADD, 16'h5000, 16'h0300, 8'd2, 1'b0);
    send_request(REQ_ADVERT, 16'h5002, 16'h5001, 8'd0, 1'b1);
    send_request(REQ_ADVERT, 16'h4005, 16'h0300, 8'd0, 1'b0);
    send_request(REQ_REMOVE, 16'h4000, '0, '0, 1'b0);
    send_request(REQ_ADVERT, 16'h5002, 16'h5001, 8'd0, 1'b1);
    drain_requests();
  endtask

  task automatic test_random_traffic;
    logic [ADDR_BITS-1:0] nbr;
    logic                 first;
    int                   pick;
    int                   len;
    int                   stop_at;
    for (int i = 0; i < POOL_SIZE; i++)
      addr_pool[i] = ADDR_BITS'($urandom_range(OWN_ADDR_MAX));
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_BCAST;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_own_address(OWN_ADDR_MAX);
        1: set_own_address(addr_pool[$urandom_range(POOL_SIZE - 1, 2)]);
        2: set_own_address('0);
        default: set_own_address(ADDR_BITS'($urandom_range(OWN_ADDR_MAX)));
      endcase
      gap_pct = (phase == 1) ? 0 : 8;
      stop_at = requests_sent + PHASE_REQUESTS;
      while (requests_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          nbr = pick_address();
          len = $urandom_range(6, 1);
          for (int k = 0; k < len; k++) begin
            first = (k == 0);
            if ($urandom_range(19) == 0) first = !first;
            send_request(REQ_ADVERT, pick_address(), nbr, pick_hops(), first);
          end
        end else if (pick < 55) begin
          send_request(REQ_ADD, pick_address(), pick_address(), pick_hops(),
                       1'($urandom_range(1)));
        end else if (pick < 75) begin
          send_request(($urandom_range(9) == 0) ?
                       REQ_BITS'($urandom_range(REQ_RSVD_LAST, REQ_RSVD_FIRST)) : REQ_LOOKUP,
                       pick_address(), ADDR_BITS'($urandom), HOP_BITS'($urandom),
                       1'($urandom_range(1)));
        end else if (pick < 90) begin
          send_request(REQ_REMOVE, pick_address(), ADDR_BITS'($urandom),
                       HOP_BITS'($urandom), 1'($urandom_range(1)));
        end else if (pick < 92) begin
          send_request(REQ_CLEAR, pick_address(), ADDR_BITS'($urandom),
                       HOP_BITS'($urandom), 1'($urandom_range(1)));
        end else begin
          send_request(REQ_BITS'($urandom_range(REQ_RSVD_LAST)), ADDR_BITS'($urandom),
                       ADDR_BITS'($urandom), HOP_BITS'($urandom),
                       1'($urandom_range(1)));
        end
      end
      drain_requests();
    end
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    request       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    route_changed = 1'b0;
    route_count   = 0;
    own_addr      = '0;
    mismatches    = 0;
    requests_sent = 0;
    gap_pct       = 8;
    cycle_count   = 0;
    for (int i = 0; i < ENTRIES; i++) route_valid[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_own_address_register();
    test_lookups_on_empty_table();
    test_direct_add();
    test_advertisement();
    test_remove_and_clear();
    test_table_full();
    test_random_traffic();

    if (mismatches == 0) begin
      $display("distance_vector_route_table_top_tb: done, clean");
    end else begin
      $display("distance_vector_route_table_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/dvrt_pkg.sv
hdl/dvrt_ctrl.sv
hdl/dvrt_dpath.sv
hdl/distance_vector_route_table_top.sv
bench/distance_vector_route_table_top_tb.sv
